// File: sv/phx_pkg.sv
// Shared types and constants for the Phoenix orbit engine.
// No dependencies; compiled first.
`default_nettype none

package phx_pkg;

    localparam int WORD_BITS = 32;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_FRAC_BITS    = 3'd0;
    localparam logic [2:0] REG_VARIANT      = 3'd1;
    localparam logic [2:0] REG_POWER_COUNT  = 3'd2;
    localparam logic [2:0] REG_P2_RE        = 3'd3;
    localparam logic [2:0] REG_P2_IM        = 3'd4;
    localparam logic [2:0] REG_ESCAPE_LIMIT = 3'd5;

    // Variant codes
    localparam logic [2:0] VAR_CLASSIC_REAL = 3'd0;
    localparam logic [2:0] VAR_CLASSIC_CPLX = 3'd1;
    localparam logic [2:0] VAR_PLUS_REAL    = 3'd2;
    localparam logic [2:0] VAR_PLUS_CPLX    = 3'd3;
    localparam logic [2:0] VAR_MINUS_REAL   = 3'd4;
    localparam logic [2:0] VAR_MINUS_CPLX   = 3'd5;

    // Complex-multiply pass being run by the datapath
    typedef enum logic [2:0] {
        PH_POW  = 3'd0,  // t = z * t
        PH_B    = 3'd1,  // b = z * z + c'
        PH_CL   = 3'd2,  // acc = z * z + c'
        PH_N    = 3'd3,  // acc = t * b
        PH_TAIL = 3'd4,  // acc += q * y (p2 * y in complex modes)
        PH_SQ   = 3'd5   // squares of z for escape test
    } t_phase;

    typedef struct packed {
        logic       load_start;
        logic       setup;
        logic       mul;
        logic       acc;
        logic       next;
        logic       done;
        logic       cplx;
        t_phase     phase;
        logic [1:0] term;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// File: sv/phx_ifs.sv
// Valid/ready channel interfaces for request and result transfers.
// Depends on phx_pkg for the word width.
`default_nettype none

interface phx_in_if;
    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic signed [phx_pkg::WORD_BITS-1:0] start_z_re;
    logic signed [phx_pkg::WORD_BITS-1:0] start_z_im;
    logic signed [phx_pkg::WORD_BITS-1:0] param_re;
    logic signed [phx_pkg::WORD_BITS-1:0] param_im;

    modport source (output valid, req_type, start_z_re, start_z_im, param_re, param_im,
                    input ready);
    modport sink   (input valid, req_type, start_z_re, start_z_im, param_re, param_im,
                    output ready);
endinterface

interface phx_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [phx_pkg::WORD_BITS-1:0] z_re;
    logic signed [phx_pkg::WORD_BITS-1:0] z_im;
    logic                            escaped;

    modport source (output valid, z_re, z_im, escaped, input ready);
    modport sink   (input valid, z_re, z_im, escaped, output ready);
endinterface

`default_nettype wire

// File: sv/phoenix_fractal_iteration_step_top.sv
// Phoenix fractal orbit engine, fixed point.
// Channels: i_in (sink) carries one request per transfer; req_type 0 starts an
//   orbit (loads z, latches p, clears the previous-orbit value y), req_type 1
//   runs one Phoenix iteration. o_out (source) returns one result per request:
//   the new z and an escape flag (|z|^2 >= escape_limit, or square overflow).
// Config: APB-style write/read port, registers at byte address 4*index.
//   Write only while the block is idle.
// Schedule: one shared 32x32 multiplier; each fixed-point multiply is a multiply
//   step then an accumulate step. Start: the escape squares, then the result.
//   Iterate: a setup step, then complex multiply passes (a multiply and accumulate
//   per term, then a next step); classic = 2 passes, plus = k+1, minus = k+2 passes
//   (k = clamped power_count), then escape squares. One request in flight at a time.
// Output: a result register holds the transfer; the next request is accepted
//   while a result still waits, and the engine stalls in its final step only if
//   a second result is ready before the first is taken.
// Reset (synchronous, active low): config to defaults, orbit state to zero,
//   output channel empty.
// Depends on phx_pkg, phx_ifs, phx_ctrl, phx_dp.
`default_nettype none

module phoenix_fractal_iteration_step_top #(
    parameter int MAX_POWER = 15
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    phx_in_if.sink           i_in,
    phx_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import phx_pkg::*;

    logic [4:0]         r_frac_bits;
    logic [2:0]         r_variant;
    logic [3:0]         r_power_count;
    logic signed [31:0] r_p2_re, r_p2_im;
    logic [31:0]        r_escape_limit;

    logic               cfg_wr;
    logic [2:0]         cfg_idx;
    t_cmd               cmd;
    t_sts               sts;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_bits    <= 5'd29;
            r_variant      <= VAR_CLASSIC_REAL;
            r_power_count  <= 4'd1;
            r_p2_re        <= '0;
            r_p2_im        <= '0;
            r_escape_limit <= 32'h8000_0000;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FRAC_BITS:    r_frac_bits    <= pwdata[4:0];
                REG_VARIANT:      r_variant      <= pwdata[2:0];
                REG_POWER_COUNT:  r_power_count  <= pwdata[3:0];
                REG_P2_RE:        r_p2_re        <= pwdata;
                REG_P2_IM:        r_p2_im        <= pwdata;
                REG_ESCAPE_LIMIT: r_escape_limit <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_FRAC_BITS:    prdata = {27'd0, r_frac_bits};
            REG_VARIANT:      prdata = {29'd0, r_variant};
            REG_POWER_COUNT:  prdata = {28'd0, r_power_count};
            REG_P2_RE:        prdata = r_p2_re;
            REG_P2_IM:        prdata = r_p2_im;
            REG_ESCAPE_LIMIT: prdata = r_escape_limit;
            default:          prdata = '0;
        endcase
    end

    phx_ctrl #(.MAX_POWER(MAX_POWER)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_in_req_type (i_in.req_type),
        .o_in_ready    (i_in.ready),
        .i_variant     (r_variant),
        .i_power_count (r_power_count),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    phx_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_frac_bits    (r_frac_bits),
        .i_p2_re        (r_p2_re),
        .i_p2_im        (r_p2_im),
        .i_escape_limit (r_escape_limit),
        .i_start_z_re   (i_in.start_z_re),
        .i_start_z_im   (i_in.start_z_im),
        .i_param_re     (i_in.param_re),
        .i_param_im     (i_in.param_im),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_z_re         (o_out.z_re),
        .o_z_im         (o_out.z_im),
        .o_escaped      (o_out.escaped),
        .o_sts          (sts)
    );

endmodule

`default_nettype wire

// File: sv/phx_ctrl.sv
// Sequencer for the Phoenix orbit engine: walks multiply passes and terms.
// Depends on phx_pkg; drives phx_dp through a t_cmd struct.
`default_nettype none

module phx_ctrl #(
    parameter int MAX_POWER = 15
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    input  wire logic         i_in_req_type,
    output logic              o_in_ready,
    input  wire logic [2:0]   i_variant,
    input  wire logic [3:0]   i_power_count,
    input  wire phx_pkg::t_sts i_sts,
    output phx_pkg::t_cmd     o_cmd
);
    import phx_pkg::*;

    localparam int CW = (MAX_POWER > 1) ? $clog2(MAX_POWER) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SETUP = 6'b000010,
        S_MUL   = 6'b000100,
        S_ACC   = 6'b001000,
        S_NEXT  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    logic [1:0]      r_term, n_term;
    logic [CW-1:0]   r_pow, n_pow;
    logic            r_cplx, n_cplx;
    logic            r_minus, n_minus;
    logic            r_classic, n_classic;

    logic            accept;
    int              k_eff;
    logic [CW-1:0]   pow_dec;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign pow_dec    = r_pow - CW'(1);

    always_comb begin
        k_eff = int'(i_power_count);
        if (k_eff < 1) begin
            k_eff = 1;
        end
        if (k_eff > MAX_POWER) begin
            k_eff = MAX_POWER;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_term    = r_term;
        n_pow     = r_pow;
        n_cplx    = r_cplx;
        n_minus   = r_minus;
        n_classic = r_classic;
        o_cmd     = '0;
        o_cmd.cplx  = r_cplx;
        o_cmd.phase = r_phase;
        o_cmd.term  = r_term;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_term = 2'd0;
                    if (!i_in_req_type) begin
                        o_cmd.load_start = 1'b1;
                        n_phase = PH_SQ;
                        n_state = S_MUL;
                    end else begin
                        n_cplx    = (i_variant == VAR_CLASSIC_CPLX) ||
                                    (i_variant == VAR_PLUS_CPLX) ||
                                    (i_variant == VAR_MINUS_CPLX);
                        n_minus   = (i_variant == VAR_MINUS_REAL) ||
                                    (i_variant == VAR_MINUS_CPLX);
                        n_classic = !((i_variant == VAR_PLUS_REAL) ||
                                      (i_variant == VAR_PLUS_CPLX) || n_minus);
                        n_pow     = CW'(k_eff - 1);
                        n_state   = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                if (r_classic) begin
                    n_phase = PH_CL;
                end else if (r_pow != '0) begin
                    n_phase = PH_POW;
                end else if (r_minus) begin
                    n_phase = PH_B;
                end else begin
                    n_phase = PH_N;
                end
                n_term  = 2'd0;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_phase == PH_SQ && r_term == 2'd1) begin
                    n_state = S_DONE;
                end else if (r_term == 2'd3) begin
                    n_state = S_NEXT;
                end else begin
                    n_term  = r_term + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_NEXT: begin
                o_cmd.next = 1'b1;
                n_term  = 2'd0;
                n_state = S_MUL;
                case (r_phase)
                    PH_POW: begin
                        n_pow = pow_dec;
                        if (pow_dec == '0) begin
                            n_phase = r_minus ? PH_B : PH_N;
                        end
                    end
                    PH_B:    n_phase = PH_N;
                    PH_N:    n_phase = PH_TAIL;
                    PH_CL:   n_phase = PH_TAIL;
                    PH_TAIL: n_phase = PH_SQ;
                    default: n_phase = PH_SQ;
                endcase
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_SQ;
            r_term    <= 2'd0;
            r_pow     <= '0;
            r_cplx    <= 1'b0;
            r_minus   <= 1'b0;
            r_classic <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_term    <= n_term;
            r_pow     <= n_pow;
            r_cplx    <= n_cplx;
            r_minus   <= n_minus;
            r_classic <= n_classic;
        end
    end

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state not one-hot");

    a_mul_then_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> (r_state == S_ACC))
        else $error("multiply not followed by accumulate");

    a_start_to_sq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_in_req_type) |=> (r_phase == PH_SQ && r_term == 2'd0))
        else $error("start did not go to escape squares");

    a_sq_two_terms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SQ && r_state == S_ACC) |-> (r_term == 2'd0 || r_term == 2'd1))
        else $error("escape squares ran past two terms");

endmodule

`default_nettype wire

// File: sv/phx_dp.sv
// Datapath: orbit registers, one shared 32x32 fixed-point multiplier,
// complex accumulator, escape test and the result register. Uses phx_pkg.
`default_nettype none

module phx_dp (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire phx_pkg::t_cmd         i_cmd,
    input  wire logic [4:0]            i_frac_bits,
    input  wire logic signed [31:0]    i_p2_re,
    input  wire logic signed [31:0]    i_p2_im,
    input  wire logic [31:0]           i_escape_limit,
    input  wire logic signed [31:0]    i_start_z_re,
    input  wire logic signed [31:0]    i_start_z_im,
    input  wire logic signed [31:0]    i_param_re,
    input  wire logic signed [31:0]    i_param_im,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic signed [31:0]         o_z_re,
    output logic signed [31:0]         o_z_im,
    output logic                       o_escaped,
    output phx_pkg::t_sts              o_sts
);
    import phx_pkg::*;

    localparam int W = WORD_BITS;

    logic signed [W-1:0]   r_z_re, r_z_im, r_y_re, r_y_im, r_c_re, r_c_im;
    logic signed [W-1:0]   r_t_re, r_t_im, r_b_re, r_b_im;
    logic signed [W-1:0]   r_acc_re, r_acc_im, r_sq_re, r_sq_im;
    logic signed [2*W-1:0] r_prod;
    logic                  r_out_valid;
    logic signed [W-1:0]   r_out_re, r_out_im;
    logic                  r_out_esc;

    logic signed [W-1:0]   x_re, x_im, y_re, y_im, op_a, op_b;
    logic signed [W-1:0]   cadd_im, init_re, init_im, f;
    logic signed [2*W-1:0] prod_sh;
    logic [W:0]            mag;
    logic                  esc;

    assign cadd_im = i_cmd.cplx ? r_c_im : '0;

    // operand selection per pass
    always_comb begin
        x_re = r_z_re; x_im = r_z_im;
        y_re = r_z_re; y_im = r_z_im;
        init_re = '0;  init_im = '0;
        case (i_cmd.phase)
            PH_POW: begin
                y_re = r_t_re; y_im = r_t_im;
            end
            PH_B, PH_CL: begin
                init_re = r_c_re; init_im = cadd_im;
            end
            PH_N: begin
                x_re = r_t_re; x_im = r_t_im;
                y_re = r_b_re; y_im = r_b_im;
            end
            PH_TAIL: begin
                // complex modes scale y by p2, real modes by q
                x_re = i_cmd.cplx ? i_p2_re : r_c_im;
                x_im = i_cmd.cplx ? i_p2_im : '0;
                y_re = r_y_re; y_im = r_y_im;
                init_re = r_acc_re; init_im = r_acc_im;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (i_cmd.term)
            2'd0: begin op_a = x_re; op_b = y_re; end
            2'd1: begin op_a = x_im; op_b = y_im; end
            2'd2: begin op_a = x_re; op_b = y_im; end
            default: begin op_a = x_im; op_b = y_re; end
        endcase
    end

    assign prod_sh = r_prod >>> i_frac_bits;
    assign f       = prod_sh[W-1:0];

    // escape: negative square means overflow, counts as escaped
    assign mag = {1'b0, r_sq_re} + {1'b0, r_sq_im};
    assign esc = r_sq_re[W-1] || r_sq_im[W-1] || (mag >= {1'b0, i_escape_limit});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= op_a * op_b;
        end
        if (i_cmd.acc) begin
            if (i_cmd.phase == PH_SQ) begin
                if (i_cmd.term == 2'd0) begin
                    r_sq_re <= f;
                end else begin
                    r_sq_im <= f;
                end
            end else begin
                case (i_cmd.term)
                    2'd0: begin
                        r_acc_re <= init_re + f;
                        r_acc_im <= init_im;
                    end
                    2'd1:    r_acc_re <= r_acc_re - f;
                    default: r_acc_im <= r_acc_im + f;
                endcase
            end
        end
        if (i_cmd.setup) begin
            r_t_re <= r_z_re;
            r_t_im <= r_z_im;
            r_b_re <= r_z_re + r_c_re;
            r_b_im <= r_z_im + cadd_im;
        end
        if (i_cmd.next && i_cmd.phase == PH_POW) begin
            r_t_re <= r_acc_re;
            r_t_im <= r_acc_im;
        end
        if (i_cmd.next && i_cmd.phase == PH_B) begin
            r_b_re <= r_acc_re;
            r_b_im <= r_acc_im;
        end
        if (i_cmd.done) begin
            r_out_re  <= r_z_re;
            r_out_im  <= r_z_im;
            r_out_esc <= esc;
        end
    end

    // orbit state resets to zero so an iterate before any start runs from zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_re <= '0; r_z_im <= '0;
            r_y_re <= '0; r_y_im <= '0;
            r_c_re <= '0; r_c_im <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_start) begin
                r_z_re <= i_start_z_re;
                r_z_im <= i_start_z_im;
                r_c_re <= i_param_re;
                r_c_im <= i_param_im;
                r_y_re <= '0;
                r_y_im <= '0;
            end else if (i_cmd.next && i_cmd.phase == PH_TAIL) begin
                r_y_re <= r_z_re;
                r_y_im <= r_z_im;
                r_z_re <= r_acc_re;
                r_z_im <= r_acc_im;
            end
            if (i_cmd.done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_z_re         = r_out_re;
    assign o_z_im         = r_out_im;
    assign o_escaped      = r_out_esc;

endmodule

`default_nettype wire
